/* design/lcdenc_pkg.sv */
// Shared types, codes and constants of the character LCD command encoder.
package lcdenc_pkg;

	localparam int MAX_DIGITS  = 5;
	localparam int JOB_BYTES   = 9;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [15:0] DIV10_MAGIC = 16'hCCCD;

	localparam logic [7:0] BIT_ENABLE    = 8'h04;
	localparam logic [7:0] BIT_SELECT    = 8'h01;
	localparam logic [7:0] BIT_BACKLIGHT = 8'h08;

	localparam logic [2:0] DC_DISPLAY = 3'b100;
	localparam logic [2:0] DC_CURSOR  = 3'b010;
	localparam logic [2:0] DC_BLINK   = 3'b001;

	typedef enum logic [3:0] {
		CMD_INIT       = 4'd0,
		CMD_CLEAR      = 4'd1,
		CMD_HOME       = 4'd2,
		CMD_DISP_OFF   = 4'd3,
		CMD_DISP_ON    = 4'd4,
		CMD_BLINK_OFF  = 4'd5,
		CMD_BLINK_ON   = 4'd6,
		CMD_CURSOR_OFF = 4'd7,
		CMD_CURSOR_ON  = 4'd8,
		CMD_SET_CURSOR = 4'd9,
		CMD_CHAR       = 4'd10,
		CMD_GLYPH      = 4'd11,
		CMD_NUMBER     = 4'd12
	} cmd_t;

	typedef enum logic {
		FR_IDLE,
		FR_DIGITS
	} front_state_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_POWER,
		BK_PREFIX,
		BK_BODY
	} back_state_t;

	typedef struct packed {
		logic [2:0] rows_in_use;
		logic       backlight_on;
	} cfg_t;

	typedef struct packed {
		logic       sel;
		logic       long_wait;
		logic [7:0] value;
	} lcd_byte_t;

	typedef struct packed {
		logic                        init;
		logic [3:0]                  count;
		lcd_byte_t [JOB_BYTES-1:0]   bytes;
	} job_t;

	function automatic lcd_byte_t mk_byte(input logic sel, input logic long_wait,
			input logic [7:0] value);
		lcd_byte_t b;
		b.sel       = sel;
		b.long_wait = long_wait;
		b.value     = value;
		return b;
	endfunction

	function automatic logic [7:0] row_base(input logic [1:0] r);
		logic [7:0] v;
		case (r)
			2'd0: v = 8'h00;
			2'd1: v = 8'h40;
			2'd2: v = 8'h14;
			default: v = 8'h54;
		endcase
		return v;
	endfunction

endpackage

/* design/lcdenc_front.sv */
// Front end: accepts commands, keeps the display-control shadow, builds byte jobs.
module lcdenc_front import lcdenc_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [111:0] s_tdata,
	input  logic [3:0]   s_tuser,
	input  cfg_t         cfg,
	input  logic         queue_full,
	output logic         push,
	output job_t         push_job
);

	front_state_t state_q, state_d;
	logic [2:0]   dc_q, dc_next;
	logic [15:0]  num_q;
	logic [2:0]   ndig_q;
	job_t         digits_q, digit_job, direct_job;
	logic         direct_valid, ctrl_cmd, accept, digit_done;

	logic [7:0]   row, column, char_code, glyph_slot;
	logic [63:0]  glyph_rows;
	logic [15:0]  number;
	logic [2:0]   rows_eff;
	logic [1:0]   rmax, rsel;
	logic [7:0]   cur_addr;
	logic [31:0]  prod;
	logic [12:0]  quot;
	logic [15:0]  rem_full;

	assign row        = s_tdata[7:0];
	assign column     = s_tdata[15:8];
	assign char_code  = s_tdata[23:16];
	assign glyph_slot = s_tdata[31:24];
	assign glyph_rows = s_tdata[95:32];
	assign number     = s_tdata[111:96];

	assign accept = s_tvalid && s_tready;

	always_comb begin
		rows_eff = cfg.rows_in_use;
		if (rows_eff == 3'd0) rows_eff = 3'd1;
		if (rows_eff > 3'd4) rows_eff = 3'd4;
		rmax     = 2'(rows_eff - 3'd1);
		rsel     = (row > {6'b0, rmax}) ? rmax : row[1:0];
		cur_addr = column + row_base(rsel);
	end

	always_comb begin
		direct_job   = '0;
		direct_valid = 1'b1;
		ctrl_cmd     = 1'b0;
		dc_next      = dc_q;
		case (cmd_t'(s_tuser)) 
			CMD_INIT: begin
				direct_job.init     = 1'b1;
				direct_job.count    = 4'd5;
				direct_job.bytes[0] = mk_byte(1'b0, 1'b0, 8'h28);
				direct_job.bytes[1] = mk_byte(1'b0, 1'b0, {5'b00001, DC_DISPLAY});
				direct_job.bytes[2] = mk_byte(1'b0, 1'b1, 8'h01);
				direct_job.bytes[3] = mk_byte(1'b0, 1'b0, 8'h06);
				direct_job.bytes[4] = mk_byte(1'b0, 1'b1, 8'h02);
				dc_next             = DC_DISPLAY;
			end
			CMD_CLEAR: begin
				direct_job.count    = 4'd1;
				direct_job.bytes[0] = mk_byte(1'b0, 1'b1, 8'h01);
			end
			CMD_HOME: begin
				direct_job.count    = 4'd1;
				direct_job.bytes[0] = mk_byte(1'b0, 1'b1, 8'h02);
			end
			CMD_DISP_OFF: begin
				dc_next  = dc_q & ~DC_DISPLAY;
				ctrl_cmd = 1'b1;
			end
			CMD_DISP_ON: begin
				dc_next  = dc_q | DC_DISPLAY;
				ctrl_cmd = 1'b1;
			end
			CMD_BLINK_OFF: begin
				dc_next  = dc_q & ~DC_BLINK;
				ctrl_cmd = 1'b1;
			end
			CMD_BLINK_ON: begin
				dc_next  = dc_q | DC_BLINK;
				ctrl_cmd = 1'b1;
			end
			CMD_CURSOR_OFF: begin
				dc_next  = dc_q & ~DC_CURSOR;
				ctrl_cmd = 1'b1;
			end
			CMD_CURSOR_ON: begin
				dc_next  = dc_q | DC_CURSOR;
				ctrl_cmd = 1'b1;
			end
			CMD_SET_CURSOR: begin
				direct_job.count    = 4'd1;
				direct_job.bytes[0] = mk_byte(1'b0, 1'b0, 8'h80 | cur_addr);
			end
			CMD_CHAR: begin
				direct_job.count    = 4'd1;
				direct_job.bytes[0] = mk_byte(1'b1, 1'b0, char_code);
			end
			CMD_GLYPH: begin
				direct_job.count    = 4'd9;
				direct_job.bytes[0] = mk_byte(1'b0, 1'b0, {2'b01, glyph_slot[2:0], 3'b000});
				for (int i = 0; i < 8; i++) begin
					direct_job.bytes[i+1] = mk_byte(1'b1, 1'b0, glyph_rows[8*i +: 8]);
				end
			end
			default: direct_valid = 1'b0;
		endcase
		if (ctrl_cmd) begin
			direct_job.count    = 4'd1;
			direct_job.bytes[0] = mk_byte(1'b0, 1'b0, {5'b00001, dc_next});
		end
	end

	// one decimal digit per cycle, least significant first
	always_comb begin
		prod     = 32'(num_q) * 32'(DIV10_MAGIC);
		quot     = prod[31:19];
		rem_full = num_q - (16'({quot, 3'b000}) + 16'({quot, 1'b0}));
		digit_job       = digits_q;
		digit_job.init  = 1'b0;
		digit_job.count = 4'(ndig_q) + 4'd1;
		digit_job.bytes = {digits_q.bytes[JOB_BYTES-2:0],
			mk_byte(1'b1, 1'b0, {4'h3, rem_full[3:0]})};
		digit_done = (quot == 13'd0) || (ndig_q == 3'(MAX_DIGITS - 1));
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			FR_IDLE:   if (accept && s_tuser == CMD_NUMBER) state_d = FR_DIGITS;
			FR_DIGITS: if (digit_done) state_d = FR_IDLE;
			default:   state_d = FR_IDLE;
		endcase
	end

	always_comb begin
		s_tready = (state_q == FR_IDLE) && !queue_full;
		if (state_q == FR_DIGITS) begin
			push     = digit_done;
			push_job = digit_job;
		end else begin
			push     = accept && direct_valid;
			push_job = direct_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FR_IDLE;
			dc_q    <= 3'b000;
		end else begin
			state_q <= state_d;
			if (accept) dc_q <= dc_next;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			num_q    <= number;
			ndig_q   <= 3'd0;
			digits_q <= '0;
		end else if (state_q == FR_DIGITS) begin
			num_q    <= 16'(quot);
			ndig_q   <= ndig_q + 3'd1;
			digits_q <= digit_job;
		end
	end

endmodule

/* design/lcdenc_queue.sv */
// Short job queue between the front end and the byte sequencer.
module lcdenc_queue import lcdenc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	output logic full,
	input  logic pop,
	output job_t pop_job,
	output logic empty
);

	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	job_t          slots_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_q, rd_q;
	logic [CW-1:0] cnt_q;

	assign full    = cnt_q == CW'(QUEUE_DEPTH);
	assign empty   = cnt_q == '0;
	assign pop_job = slots_q[rd_q];

	function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
		return (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + PW'(1);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= bump(wr_q);
			if (pop) rd_q <= bump(rd_q);
			if (push && !pop) cnt_q <= cnt_q + CW'(1);
			else if (pop && !push) cnt_q <= cnt_q - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push) slots_q[wr_q] <= push_job;
	end

endmodule

/* design/lcdenc_back.sv */
// Back end: expands each job into nibble strobes of expander bytes with waits.
module lcdenc_back import lcdenc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        queue_empty,
	input  job_t        pop_job,
	output logic        pop,
	input  cfg_t        cfg,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,
	output logic        m_tlast
);

	back_state_t state_q, state_d;
	job_t        job_q;
	logic [3:0]  byte_idx_q;
	logic        half_q;
	logic [1:0]  phase_q, nib_q;

	logic        out_valid_q, out_last_q;
	logic [7:0]  out_byte_q;
	logic [19:0] out_wait_q;

	logic        load, active, cur_last;
	lcd_byte_t   cur;
	logic [7:0]  base, cur_byte;
	logic [19:0] extra, cur_wait;

	assign load   = !out_valid_q || m_tready;
	assign active = state_q != BK_IDLE;
	assign cur    = job_q.bytes[byte_idx_q];

	always_comb begin
		base     = 8'h00;
		extra    = 20'd0;
		cur_last = 1'b0;
		case (state_q)
			BK_PREFIX: begin
				base = (nib_q == 2'd3) ? 8'h20 : 8'h30;
				case (nib_q)
					2'd0, 2'd1: extra = 20'd4500;
					2'd2:       extra = 20'd150;
					default:    extra = 20'd0;
				endcase
			end
			BK_BODY: begin
				base = (half_q ? {cur.value[3:0], 4'h0} : {cur.value[7:4], 4'h0})
					| (cur.sel ? BIT_SELECT : 8'h00);
				extra = (half_q && cur.long_wait) ? 20'd2000 : 20'd0;
				cur_last = (phase_q == 2'd2) && half_q
					&& (byte_idx_q == job_q.count - 4'd1);
			end
			default: ;
		endcase
		if (state_q == BK_POWER) begin
			cur_byte = 8'h00;
			cur_wait = 20'd1000000;
		end else begin
			case (phase_q)
				2'd0: begin
					cur_byte = base;
					cur_wait = 20'd0;
				end
				2'd1: begin
					cur_byte = base | BIT_ENABLE;
					cur_wait = 20'd2;
				end
				default: begin
					cur_byte = base & ~BIT_ENABLE;
					cur_wait = 20'd50 + extra;
				end
			endcase
		end
		if (cfg.backlight_on) cur_byte = cur_byte | BIT_BACKLIGHT;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_IDLE:   if (!queue_empty) state_d = pop_job.init ? BK_POWER : BK_BODY;
			BK_POWER:  if (load) state_d = BK_PREFIX;
			BK_PREFIX: if (load && phase_q == 2'd2 && nib_q == 2'd3) state_d = BK_BODY;
			BK_BODY:   if (load && cur_last) state_d = BK_IDLE;
			default:   state_d = BK_IDLE;
		endcase
	end

	always_comb begin
		pop = (state_q == BK_IDLE) && !queue_empty;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			out_valid_q <= 1'b0;
			byte_idx_q  <= 4'd0;
			half_q      <= 1'b0;
			phase_q     <= 2'd0;
			nib_q       <= 2'd0;
		end else begin
			state_q <= state_d;
			if (load) out_valid_q <= active;
			if (pop) begin
				byte_idx_q <= 4'd0;
				half_q     <= 1'b0;
				phase_q    <= 2'd0;
				nib_q      <= 2'd0;
			end else if (load && (state_q == BK_PREFIX || state_q == BK_BODY)) begin
				if (phase_q == 2'd2) begin
					phase_q <= 2'd0;
					if (state_q == BK_PREFIX) begin
						nib_q <= nib_q + 2'd1;
					end else begin
						half_q <= !half_q;
						if (half_q) byte_idx_q <= byte_idx_q + 4'd1;
					end
				end else begin
					phase_q <= phase_q + 2'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) job_q <= pop_job;
		if (load) begin
			out_byte_q <= cur_byte;
			out_wait_q <= cur_wait;
			out_last_q <= cur_last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'h0, out_wait_q, out_byte_q};
	assign m_tlast  = out_last_q;

endmodule

/* design/char_lcd_nibble_command_encoder.sv */
// Top level of the character LCD command encoder: config registers and the front/queue/back chain.
//
//  channel | dir | handshake             | payload
//  s_      | in  | s_tvalid / s_tready   | s_tdata: row, column, char_code, glyph_slot,
//          |     |                       |   glyph_rows, number; s_tuser: cmd
//  m_      | out | m_tvalid / m_tready   | m_tdata: expander_byte, wait_us; m_tlast: last
//  apb     | in  | psel&penable, pready  | reg 0 rows_in_use @0x0, reg 1 backlight_on @0x4
//
// One expander byte per cycle while m_tready is high; a command's run is six bytes per
// LCD byte (init 43, glyph 54), and the sequencer passes through idle to pick up the next job.
// Print number holds the input while the divide-by-ten unit produces its decimal digits.
// Reset clears the control shadow, the queue and the sequencer; no clearing pass.
// A stall on m_ holds the output register; the two-job queue lets the front keep accepting.
module char_lcd_nibble_command_encoder import lcdenc_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [111:0] s_tdata,  // row[7:0] column[15:8] char_code[23:16] glyph_slot[31:24]
	                               // glyph_rows[95:32] number[111:96]
	input  logic [3:0]   s_tuser,  // cmd[3:0]
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [31:0]  m_tdata,  // expander_byte[7:0] wait_us[27:8] zero[31:28]
	output logic         m_tlast,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [2:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);

	cfg_t cfg_q;
	logic push, pop, full, empty;
	job_t push_job, pop_job;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rows_in_use  <= 3'd4;
			cfg_q.backlight_on <= 1'b1;
		end else if (psel && penable && pwrite && pready) begin
			if (paddr[2]) cfg_q.backlight_on <= pwdata[0];
			else cfg_q.rows_in_use <= pwdata[2:0];
		end
	end

	assign prdata = paddr[2] ? {31'b0, cfg_q.backlight_on} : {29'b0, cfg_q.rows_in_use};

	lcdenc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.cfg        (cfg_q),
		.queue_full (full),
		.push       (push),
		.push_job   (push_job)
	);

	lcdenc_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.full     (full),
		.pop      (pop),
		.pop_job  (pop_job),
		.empty    (empty)
	);

	lcdenc_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.queue_empty (empty),
		.pop_job     (pop_job),
		.pop         (pop),
		.cfg         (cfg_q),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tlast     (m_tlast)
	);

endmodule
